// ===== design/png_unf_pkg.sv =====
`timescale 1ns / 1ps

package png_unf_pkg;

    // Default sizes of the line store and of the pixel history
    localparam int MAX_ROW_BYTES_DEF   = 8192;
    localparam int MAX_PIXEL_BYTES_DEF = 4;

    // Configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 14;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_BYTES   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_BYTES = 8'd1;

    // Field widths
    localparam int BYTE_W        = 8;
    localparam int ROW_BYTES_W   = 14;
    localparam int PIXEL_BYTES_W = 3;

    // Scanline filter types
    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filt_t;

    // Item held between the accept stage and the reconstruct stage
    typedef struct packed {
        logic              is_data;    // data byte (else filter byte)
        logic              bad;        // filter byte with unknown type
        logic              row_end;    // last data byte of the row
        logic              first_row;  // no upper row yet
        logic              left_ok;    // left pixel exists
        filt_t             filter;     // filter of the current row
        logic [BYTE_W-1:0] data;       // filtered byte
    } stage_t;

endpackage

// ===== design/png_scanline_unfilter.sv =====
`timescale 1ns / 1ps

// PNG scanline unfilter. Takes the inflated image stream one byte per item on
// the s_ channel; the first byte of every row is the filter type (None, Sub,
// Up, Average, Paeth) and the next row_bytes bytes are rebuilt into raw pixel
// bytes, one result item each on the m_ channel, with m_tlast on the last
// byte of the row. A valid filter byte gives no result; a filter type above
// Paeth gives one result with m_tuser set and pixel byte zero, and that row is
// decoded as None. s_tuser marks the filter byte that opens a new image; on
// the first row and for the first pixel of a row, missing neighbors read as
// zero. Throughput is one byte per cycle in both directions while m_tready
// stays high. A result item passes the stage register and then the output
// register: the accept stage issues the read of the upper byte from the
// single-port-read line store, the second stage gets its registered data, does
// the Paeth compare and the add, writes the raw byte back to the line store
// and loads the output register. Write row_bytes and pixel_bytes only between
// items; a new row length is taken with the next filter byte in normal use.
// No clearing pass is needed after reset.
module png_scanline_unfilter #(
    parameter int MAX_ROW_BYTES   = png_unf_pkg::MAX_ROW_BYTES_DEF,
    parameter int MAX_PIXEL_BYTES = png_unf_pkg::MAX_PIXEL_BYTES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [png_unf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [png_unf_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Filtered stream in
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // [7:0] stream_byte
    input  logic                                 s_tuser,   // [0] image_start
    // Raw pixel bytes out
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [7:0]                           m_tdata,   // [7:0] pixel_byte
    output logic                                 m_tlast,   // row_end
    output logic                                 m_tuser    // [0] bad_filter
);

    import png_unf_pkg::*;

    localparam int CW = $clog2(MAX_ROW_BYTES + 1);
    localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int PW = $clog2(MAX_PIXEL_BYTES + 1);
    localparam int SW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    // Configuration registers
    logic [ROW_BYTES_W-1:0]   row_bytes_reg, row_bytes_next;
    logic [PIXEL_BYTES_W-1:0] pixel_bytes_reg, pixel_bytes_next;

    // Accept stage state
    logic [CW-1:0] col_reg, col_next;
    logic          first_row_reg, first_row_next;
    filt_t         filter_reg, filter_next;
    logic [SW-1:0] mod_reg [MAX_PIXEL_BYTES];
    logic [SW-1:0] mod_next [MAX_PIXEL_BYTES];

    // Accept stage logic
    logic          accept;
    logic [CW-1:0] rb_eff;
    logic [PW-1:0] pb_eff;
    logic [PW-1:0] pb_m1;
    logic [CW-1:0] col_cur;
    logic [CW-1:0] idx_full;
    logic [AW-1:0] idx;
    logic [SW-1:0] slot;
    logic          first_cur;
    logic          is_filter;
    logic          bad_type;
    logic          row_end;
    logic          left_ok;
    stage_t        st_in;

    // Reconstruct stage
    logic          st1_valid_reg, st1_valid_next;
    stage_t        st1_reg;
    logic [AW-1:0] st1_idx_reg;
    logic [SW-1:0] st1_slot_reg;
    logic          st1_go;
    logic          st1_result;

    // Pixel history
    logic [BYTE_W-1:0] left_hist_reg [MAX_PIXEL_BYTES];
    logic [BYTE_W-1:0] ul_hist_reg [MAX_PIXEL_BYTES];

    logic [BYTE_W-1:0] upper_rd;
    logic [BYTE_W-1:0] nb_a, nb_b, nb_c;
    logic [BYTE_W:0]   avg_sum;
    logic [BYTE_W-1:0] pred;
    logic [BYTE_W-1:0] raw;

    // Output register
    logic              m_valid_reg;
    logic [BYTE_W-1:0] m_data_reg;
    logic              m_last_reg;
    logic              m_bad_reg;

    // Paeth predictor: closest of a, b, c to a + b - c, ties to a then b
    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [9:0] da, db, dc;
        logic [9:0]        pa, pb, pc;
        da = $signed({2'b00, b}) - $signed({2'b00, c});
        db = $signed({2'b00, a}) - $signed({2'b00, c});
        dc = da + db;
        pa = (da < 0) ? 10'(-da) : 10'(da);
        pb = (db < 0) ? 10'(-db) : 10'(db);
        pc = (dc < 0) ? 10'(-dc) : 10'(dc);
        if (pa <= pb && pa <= pc) begin
            paeth = a;
        end else if (pb <= pc) begin
            paeth = b;
        end else begin
            paeth = c;
        end
    endfunction

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_comb begin
        row_bytes_next   = row_bytes_reg;
        pixel_bytes_next = pixel_bytes_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ROW_BYTES:   row_bytes_next   = cfg_data[ROW_BYTES_W-1:0];
                CFG_PIXEL_BYTES: pixel_bytes_next = cfg_data[PIXEL_BYTES_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective row length and pixel size
    always_comb begin
        if (row_bytes_reg == '0) begin
            rb_eff = CW'(1);
        end else if (32'(row_bytes_reg) > MAX_ROW_BYTES) begin
            rb_eff = CW'(MAX_ROW_BYTES);
        end else begin
            rb_eff = CW'(row_bytes_reg);
        end
        if (pixel_bytes_reg == '0) begin
            pb_eff = PW'(1);
        end else if (32'(pixel_bytes_reg) > MAX_PIXEL_BYTES) begin
            pb_eff = PW'(MAX_PIXEL_BYTES);
        end else begin
            pb_eff = PW'(pixel_bytes_reg);
        end
    end

    // Handshake: the second stage moves whenever the output register frees up
    assign st1_go   = st1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !st1_valid_reg || st1_go;
    assign accept   = s_tvalid && s_tready;

    // Accept stage: row position, line store address, history slot
    always_comb begin
        col_cur   = s_tuser ? '0 : col_reg;
        first_cur = s_tuser | first_row_reg;
        is_filter = (col_cur == '0);
        bad_type  = (s_tdata > 8'(FILT_PAETH));
        idx_full  = col_cur - CW'(1);
        idx       = idx_full[AW-1:0];
        row_end   = (col_cur >= rb_eff);
        pb_m1     = pb_eff - PW'(1);
        slot      = mod_reg[pb_m1[SW-1:0]];
        left_ok   = (32'(idx_full) >= 32'(pb_eff));

        st_in.is_data   = !is_filter;
        st_in.bad       = is_filter && bad_type;
        st_in.row_end   = !is_filter && row_end;
        st_in.first_row = first_cur;
        st_in.left_ok   = left_ok;
        st_in.filter    = filter_reg;
        st_in.data      = s_tdata;
    end

    // Next row state
    always_comb begin
        col_next       = col_reg;
        first_row_next = first_row_reg;
        filter_next    = filter_reg;
        mod_next       = mod_reg;
        if (accept) begin
            if (is_filter) begin
                col_next       = CW'(1);
                first_row_next = first_cur;
                filter_next    = bad_type ? FILT_NONE : filt_t'(s_tdata[2:0]);
                for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                    mod_next[k] = '0;
                end
            end else begin
                col_next       = row_end ? '0 : col_cur + CW'(1);
                first_row_next = row_end ? 1'b0 : first_cur;
                // Byte index modulo every possible pixel size
                for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                    mod_next[k] = (mod_reg[k] == SW'(k)) ? '0 : mod_reg[k] + SW'(1);
                end
            end
        end
    end

    // Stage register
    assign st1_valid_next = accept ? 1'b1 : (st1_go ? 1'b0 : st1_valid_reg);

    // Line store of the previous row
    png_unf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_ROW_BYTES)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (st1_go && st1_reg.is_data),
        .wr_addr (st1_idx_reg),
        .wr_data (raw),
        .rd_en   (accept),
        .rd_addr (idx),
        .rd_data (upper_rd)
    );

    // Reconstruct stage: neighbors, predictor, raw byte
    always_comb begin
        nb_b    = st1_reg.first_row ? '0 : upper_rd;
        nb_a    = st1_reg.left_ok ? left_hist_reg[st1_slot_reg] : '0;
        nb_c    = (st1_reg.left_ok && !st1_reg.first_row) ? ul_hist_reg[st1_slot_reg] : '0;
        avg_sum = {1'b0, nb_a} + {1'b0, nb_b};
        case (st1_reg.filter)
            FILT_SUB:   pred = nb_a;
            FILT_UP:    pred = nb_b;
            FILT_AVG:   pred = avg_sum[BYTE_W:1];
            FILT_PAETH: pred = paeth(nb_a, nb_b, nb_c);
            default:    pred = '0;
        endcase
        raw        = st1_reg.data + pred;
        st1_result = st1_reg.is_data || st1_reg.bad;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_bytes_reg   <= ROW_BYTES_W'(1);
            pixel_bytes_reg <= PIXEL_BYTES_W'(1);
            col_reg         <= '0;
            first_row_reg   <= 1'b1;
            filter_reg      <= FILT_NONE;
            st1_valid_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
            for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                mod_reg[k]       <= '0;
                left_hist_reg[k] <= '0;
                ul_hist_reg[k]   <= '0;
            end
        end else begin
            row_bytes_reg   <= row_bytes_next;
            pixel_bytes_reg <= pixel_bytes_next;
            col_reg         <= col_next;
            first_row_reg   <= first_row_next;
            filter_reg      <= filter_next;
            mod_reg         <= mod_next;
            st1_valid_reg   <= st1_valid_next;

            // Pixel history: cleared by filter bytes, filled by data bytes
            if (st1_go) begin
                if (st1_reg.is_data) begin
                    left_hist_reg[st1_slot_reg] <= raw;
                    ul_hist_reg[st1_slot_reg]   <= nb_b;
                end else begin
                    for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                        left_hist_reg[k] <= '0;
                        ul_hist_reg[k]   <= '0;
                    end
                end
            end

            // Output valid
            if (st1_go && st1_result) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_reg      <= st_in;
            st1_idx_reg  <= idx;
            st1_slot_reg <= slot;
        end
        if (st1_go && st1_result) begin
            m_data_reg <= st1_reg.is_data ? raw : '0;
            m_last_reg <= st1_reg.row_end;
            m_bad_reg  <= st1_reg.bad;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_bad_reg;

endmodule

// ===== design/png_unf_ram.sv =====
`timescale 1ns / 1ps

module png_unf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== verif/tb_png_scanline_unfilter.sv =====
`timescale 1ns / 1ps

module tb_png_scanline_unfilter;
    import png_unf_pkg::*;

    localparam int LINE_DEPTH   = MAX_ROW_BYTES_DEF;
    localparam int HIST_DEPTH   = MAX_PIXEL_BYTES_DEF;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1400;
    localparam int MAX_REPORTS  = 10;

    // Lowest filter type byte that the block rejects
    localparam logic [7:0] FILT_BAD_LO = 8'd5;
    // Highest register index, not mapped to any register
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_SPARE_LAST = '1;

    typedef struct packed {
        logic [7:0] pixel;
        logic       row_end;
        logic       bad;
    } pixel_out_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [7:0]             m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;

    png_scanline_unfilter DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // Unfilter state mirrored by the testbench
    logic [7:0]  line_store [LINE_DEPTH];
    bit          line_written [LINE_DEPTH];
    logic [7:0]  left_hist [HIST_DEPTH];
    logic [7:0]  upleft_hist [HIST_DEPTH];
    filt_t       row_filt;
    int unsigned col_pos;
    bit          first_row;
    int unsigned row_len_reg;
    int unsigned pix_len_reg;

    pixel_out_t  pixel_expect_q [$];
    int          fail_count;
    int          items_sent;
    int          gap_max;
    int          stall_max;
    int          stall_left;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int unsigned eff_row_len();
        if (row_len_reg == 0) return 1;
        if (row_len_reg > LINE_DEPTH) return LINE_DEPTH;
        return row_len_reg;
    endfunction

    function automatic int unsigned eff_pix_len();
        if (pix_len_reg == 0) return 1;
        if (pix_len_reg > HIST_DEPTH) return HIST_DEPTH;
        return pix_len_reg;
    endfunction

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        int p, da, db, dc;
        p  = int'(a) + int'(b) - int'(c);
        da = p - int'(a);
        db = p - int'(b);
        dc = p - int'(c);
        if (da < 0) da = -da;
        if (db < 0) db = -db;
        if (dc < 0) dc = -dc;
        if (da <= db && da <= dc) return a;
        if (db <= dc) return b;
        return c;
    endfunction

    // True when this item would fetch an upper byte never written since reset
    function automatic bit reads_unwritten(input logic start);
        int unsigned idx;
        if (start || col_pos == 0 || first_row) return 1'b0;
        idx = col_pos - 1;
        if (idx >= LINE_DEPTH) idx = LINE_DEPTH - 1;
        return !line_written[idx];
    endfunction

    // Append one expected result item at the tail
    function automatic void queue_result(input pixel_out_t res);
        pixel_expect_q.insert(pixel_expect_q.size(), res);
    endfunction

    // Rebuild one accepted stream byte and queue the result it causes
    function automatic void unfilter_byte(input logic [7:0] x, input logic start);
        int unsigned rb, pb, idx, slot;
        logic [7:0]  a, b, c, pred, raw;
        logic [8:0]  sum;
        pixel_out_t  res;
        rb = eff_row_len();
        pb = eff_pix_len();
        if (start) begin
            col_pos   = 0;
            first_row = 1'b1;
        end

        // Filter type byte
        if (col_pos == 0) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                left_hist[k]   = '0;
                upleft_hist[k] = '0;
            end
            col_pos = 1;
            if (x > 8'(FILT_PAETH)) begin
                row_filt = FILT_NONE;
                res = '{pixel: 8'h00, row_end: 1'b0, bad: 1'b1};
                queue_result(res);
            end else begin
                row_filt = filt_t'(x[2:0]);
            end
            return;
        end

        // Data byte: neighbors, missing ones read as zero
        idx = col_pos - 1;
        if (idx >= LINE_DEPTH) idx = LINE_DEPTH - 1;
        slot = (idx % pb) % HIST_DEPTH;
        b = first_row ? 8'h00 : line_store[idx];
        a = (idx >= pb) ? left_hist[slot] : 8'h00;
        c = (idx >= pb && !first_row) ? upleft_hist[slot] : 8'h00;
        sum = {1'b0, a} + {1'b0, b};
        case (row_filt)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = sum[8:1];
            FILT_PAETH: pred = paeth_pick(a, b, c);
            default:    pred = 8'h00;
        endcase
        raw = x + pred;

        upleft_hist[slot]  = b;
        left_hist[slot]    = raw;
        line_store[idx]    = raw;
        line_written[idx]  = 1'b1;

        res.pixel = raw;
        res.bad   = 1'b0;
        if (col_pos >= rb) begin
            res.row_end = 1'b1;
            col_pos     = 0;
            first_row   = 1'b0;
        end else begin
            res.row_end = 1'b0;
            col_pos     = (col_pos + 1) & 14'h3FFF;
        end
        queue_result(res);
    endfunction

    function automatic logic [7:0] rand_pixel_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Send one stream item; entered and left at a falling edge
    task automatic send_stream_byte(input logic [7:0] val, input logic start);
        int   gap;
        logic st;
        gap = $urandom_range(0, gap_max);
        // an upper byte never written must not be fetched: restart the image
        st  = start | reads_unwritten(start);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= st;
        do @(posedge aclk); while (!s_tready);
        unfilter_byte(val, st);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_row(input logic [7:0] filt, input int unsigned n, input logic start);
        send_stream_byte(filt, start);
        for (int unsigned k = 0; k < n; k++) send_stream_byte(rand_pixel_byte(), 1'b0);
    endtask

    task automatic send_pair_row(input logic [7:0] filt, input logic [7:0] d0,
                                 input logic [7:0] d1, input logic start);
        send_stream_byte(filt, start);
        send_stream_byte(d0, 1'b0);
        send_stream_byte(d1, 1'b0);
    endtask

    // Hold the stream until all results are out and the pipeline is empty
    task automatic wait_block_idle();
        s_tvalid <= 1'b0;
        while (pixel_expect_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input int unsigned index, input int unsigned data);
        wait_block_idle();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_INDEX_W'(index);
        cfg_data  <= CFG_DATA_W'(data);
        do @(posedge aclk); while (!cfg_ready);
        if (index == 32'(CFG_ROW_BYTES)) row_len_reg = data & 32'h3FFF;
        else if (index == 32'(CFG_PIXEL_BYTES)) pix_len_reg = data & 32'h7;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Register reset values: one byte rows, no image start on the first row
    task automatic test_reset_defaults();
        send_stream_byte(8'(FILT_NONE), 1'b0);
        send_stream_byte(8'hA5, 1'b0);
        send_stream_byte(8'(FILT_SUB), 1'b0);
        send_stream_byte(8'h5A, 1'b0);
    endtask

    // Sub, Up, Average and Paeth filters, extreme bytes, rejected types, image restart mid-row
    task automatic test_filter_types();
        write_reg(CFG_ROW_BYTES, 2);
        write_reg(CFG_PIXEL_BYTES, 1);
        send_pair_row(8'(FILT_PAETH), 8'hFF, 8'h01, 1'b1);
        send_pair_row(8'(FILT_SUB),   8'h80, 8'h80, 1'b0);
        send_pair_row(8'(FILT_UP),    8'h01, 8'hFF, 1'b0);
        send_pair_row(8'(FILT_AVG),   8'hFF, 8'hFF, 1'b0);
        send_pair_row(8'(FILT_PAETH), 8'h00, 8'h7F, 1'b0);
        send_pair_row(FILT_BAD_LO,    8'h12, 8'h34, 1'b0);
        send_pair_row(8'hFF,          8'h00, 8'hFF, 1'b0);
        // restart in the middle of a row; Up on row one sees zeros above
        send_stream_byte(8'(FILT_UP), 1'b0);
        send_stream_byte(8'h3C, 1'b0);
        send_pair_row(8'(FILT_UP), 8'h11, 8'hEE, 1'b1);
    endtask

    // Out-of-range register values and writes to unmapped indexes
    task automatic test_register_limits();
        write_reg(CFG_ROW_BYTES, 0);
        write_reg(CFG_PIXEL_BYTES, 0);
        send_row(8'(FILT_SUB), 1, 1'b1);
        send_row(8'(FILT_PAETH), 1, 1'b0);
        write_reg(CFG_ROW_BYTES, 5);
        write_reg(CFG_PIXEL_BYTES, 7);
        send_row(8'(FILT_SUB), 5, 1'b1);
        send_row(8'(FILT_PAETH), 5, 1'b0);
        write_reg(CFG_INDEX_SPARE_LAST, '1);
        write_reg(CFG_PIXEL_BYTES + 1, '0);
        send_row(8'(FILT_AVG), 5, 1'b0);
    endtask

    // Row length and pixel size rewritten in the middle of a row
    task automatic test_mid_row_changes();
        write_reg(CFG_ROW_BYTES, 6);
        write_reg(CFG_PIXEL_BYTES, 3);
        send_row(8'(FILT_PAETH), 6, 1'b1);
        send_row(8'(FILT_AVG), 2, 1'b0);
        // already past the new length: next data byte closes the row
        write_reg(CFG_ROW_BYTES, 2);
        send_stream_byte(rand_pixel_byte(), 1'b0);
        send_row(8'(FILT_SUB), 2, 1'b0);
        write_reg(CFG_ROW_BYTES, 6);
        send_row(8'(FILT_PAETH), 2, 1'b0);
        write_reg(CFG_PIXEL_BYTES, 2);
        for (int k = 0; k < 4; k++) send_stream_byte(rand_pixel_byte(), 1'b0);
        write_reg(CFG_PIXEL_BYTES, 4);
        send_row(8'(FILT_PAETH), 6, 1'b0);
    endtask

    // Random images: mostly well-formed rows, some bad types, cut rows, restarts
    task automatic test_random_images();
        int          target;
        int unsigned rows, n, sel;
        logic [7:0]  filt;
        int unsigned rb_val;
        bit          new_image;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            sel = $urandom_range(0, 19);
            if (sel < 14) rb_val = $urandom_range(1, 24);
            else if (sel < 18) rb_val = $urandom_range(25, 300);
            else if (sel == 18) rb_val = 0;
            else rb_val = $urandom_range(1, 4);
            if ($urandom_range(0, 3) != 0) write_reg(CFG_ROW_BYTES, rb_val);
            if ($urandom_range(0, 2) != 0) write_reg(CFG_PIXEL_BYTES, $urandom_range(0, 7));
            if ($urandom_range(0, 9) == 0)
                write_reg($urandom_range(CFG_PIXEL_BYTES + 1, CFG_INDEX_SPARE_LAST), $urandom);
            gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 14;
            stall_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
            new_image = ($urandom_range(0, 3) != 0);
            rows      = $urandom_range(1, 6);
            for (int unsigned r = 0; r < rows; r++) begin
                if ($urandom_range(0, 9) != 0) filt = 8'($urandom_range(FILT_NONE, FILT_PAETH));
                else filt = 8'($urandom_range(FILT_BAD_LO, 255));
                n = eff_row_len();
                if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);
                send_row(filt, n, new_image && r == 0);
                if ($urandom_range(0, 19) == 0) send_stream_byte(rand_pixel_byte(), 1'b1);
            end
        end
        gap_max   = 14;
        stall_max = 14;
    endtask

    // Row length above the limit, then the row cut short by a length rewrite
    task automatic test_max_row();
        write_reg(CFG_ROW_BYTES, '1);
        write_reg(CFG_PIXEL_BYTES, 4);
        send_row(8'(FILT_SUB), 40, 1'b1);
        write_reg(CFG_ROW_BYTES, 3);
        send_stream_byte(rand_pixel_byte(), 1'b0);
        send_row(8'(FILT_UP), 3, 1'b0);
    endtask

    // Result side ready pattern: random stall before each item
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each result item with the oldest expectation
    always @(posedge aclk) begin : result_check
        pixel_out_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got        = '{pixel: m_tdata, row_end: m_tlast, bad: m_tuser};
            stall_left = $urandom_range(0, stall_max);
            if (pixel_expect_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%t: result with nothing expected: pixel %h last %b bad %b",
                             $realtime, got.pixel, got.row_end, got.bad);
            end else begin
                want = pixel_expect_q.pop_front();
                if (got.pixel !== want.pixel || got.row_end !== want.row_end ||
                    got.bad !== want.bad) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $write("%t: mismatch: expected pixel %h last %b bad %b, ",
                               $realtime, want.pixel, want.row_end, want.bad);
                        $display("got pixel %h last %b bad %b",
                                 got.pixel, got.row_end, got.bad);
                    end
                end
            end
        end
    end

    initial begin
        aresetn    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        m_tready   = 1'b0;
        stall_left = 0;
        fail_count = 0;
        items_sent = 0;
        gap_max    = 14;
        stall_max  = 14;

        // predictor reset state
        for (int k = 0; k < HIST_DEPTH; k++) begin
            left_hist[k]   = '0;
            upleft_hist[k] = '0;
        end
        row_filt    = FILT_NONE;
        col_pos     = 0;
        first_row   = 1'b1;
        row_len_reg = 1;
        pix_len_reg = 1;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_filter_types();
        test_register_limits();
        test_mid_row_changes();
        test_random_images();
        test_max_row();

        wait_block_idle();
        if (fail_count == 0 && pixel_expect_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
